// ----- hdl/bpa_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned MAX_FRAMES   = 4096;
    localparam int unsigned NUM_ORDERS   = 11;
    localparam int unsigned RESERVED_BIT = 0;
    localparam int unsigned BUDDY_BIT    = 1;

    localparam int unsigned FLAGS_W = 16;
    localparam int unsigned ORDER_W = 4;
    localparam int unsigned FRAME_W = 12;
    localparam int unsigned COUNT_W = 13;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_UNDEF = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ARG  = 2'd1,
        ST_BAD_ST   = 2'd2,
        ST_NO_MEM   = 2'd3
    } t_status;

endpackage
`default_nettype wire

// ----- hdl/buddy_page_allocator.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over page frames with per-order doubly linked free lists.
// ---------------------------------------------------------------------------
// Takes one command (alloc, free, add page) when i_start is high and o_busy
// is low, and returns exactly one result on o_done for a single cycle; the
// receiver cannot stall it. Frame records and list links live in memories
// with one write and one read port per array (list heads are registers),
// driven by a small sequencer; a command rejected on its arguments goes
// straight to the done step, others walk the split or merge levels first.
// After reset a clearing pass over all MAX_FRAMES records initializes them
// before o_busy drops.
// ---------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int unsigned MAX_FRAMES = bpa_pkg::MAX_FRAMES,
    parameter int unsigned NUM_ORDERS = bpa_pkg::NUM_ORDERS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bpa_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [bpa_pkg::ORDER_W-1:0]  i_order,
    input  wire logic [bpa_pkg::FLAGS_W-1:0]  i_page_flags_in,
    input  wire logic [bpa_pkg::FRAME_W-1:0]  i_frame,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [bpa_pkg::FRAME_W-1:0]       o_frame_out,
    output logic [bpa_pkg::COUNT_W-1:0]       o_free_count
);

    localparam int unsigned FA_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned LK_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned OI_W = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int unsigned FW = bpa_pkg::FLAGS_W;
    localparam int unsigned OW = bpa_pkg::ORDER_W;
    localparam int unsigned CW = bpa_pkg::COUNT_W;
    localparam int unsigned XW = (LK_W > CW) ? LK_W + 1 : CW + 1;
    localparam logic [LK_W-1:0] NIL = LK_W'(MAX_FRAMES);
    localparam logic [FW-1:0] F_RES = FW'(1) << bpa_pkg::RESERVED_BIT;
    localparam logic [FW-1:0] F_BUD = FW'(1) << bpa_pkg::BUDDY_BIT;
    localparam logic [CW-1:0] FREE_MAX = {CW{1'b1}};

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_SCAN, S_UL_RD, S_UL_P, S_UL_N, S_UL_DONE,
        S_SP_STEP, S_SP_HEAD, S_PU_PREV, S_A_FIN,
        S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_M_CLR, S_F_FIN, S_PU_SELF,
        S_DONE
    } t_state;

    // frame record and link memories
    logic [FW-1:0]   m_flags [MAX_FRAMES];
    logic [OW-1:0]   m_order [MAX_FRAMES];
    logic [LK_W-1:0] m_next  [MAX_FRAMES];
    logic [LK_W-1:0] m_prev  [MAX_FRAMES];
    logic [LK_W-1:0] r_head  [NUM_ORDERS];

    logic [FW-1:0]   r_rd_flags;
    logic [OW-1:0]   r_rd_order;
    logic [LK_W-1:0] r_rd_next;
    logic [LK_W-1:0] r_rd_prev;

    t_state          r_state;
    logic [CW-1:0]   r_limit;
    logic [CW-1:0]   r_free;
    logic [1:0]      r_op;
    logic [OW-1:0]   r_req;
    logic [FW-1:0]   r_uflags;
    logic [LK_W-1:0] r_f;       // working frame
    logic [LK_W-1:0] r_b;       // buddy / split half
    logic [OW-1:0]   r_cur;
    logic [OW-1:0]   r_orig;
    logic [LK_W-1:0] r_p;
    logic [LK_W-1:0] r_n;
    logic            r_ul_alloc; // unlink belongs to alloc path
    logic [LK_W-1:0] r_clr;

    // memory port controls
    logic            w_we_f, w_we_o, w_we_n, w_we_p;
    logic [FA_W-1:0] w_a_f, w_a_o, w_a_n, w_a_p, w_ra;
    logic [FW-1:0]   w_d_f;
    logic [OW-1:0]   w_d_o;
    logic [LK_W-1:0] w_d_n, w_d_p;

    always_ff @(posedge i_clk) begin
        if (w_we_f) m_flags[w_a_f] <= w_d_f;
        if (w_we_o) m_order[w_a_o] <= w_d_o;
        if (w_we_n) m_next[w_a_n]  <= w_d_n;
        if (w_we_p) m_prev[w_a_p]  <= w_d_p;
        r_rd_flags <= m_flags[w_ra];
        r_rd_order <= m_order[w_ra];
        r_rd_next  <= m_next[w_ra];
        r_rd_prev  <= m_prev[w_ra];
    end

    function automatic logic is_link(input logic [LK_W-1:0] v);
        return v < NIL;
    endfunction

    function automatic logic [LK_W-1:0] lk(input logic [LK_W-1:0] v);
        return is_link(v) ? v : NIL;
    endfunction

    function automatic logic [LK_W-1:0] pow2(input logic [OW-1:0] o);
        return (o < OW'(LK_W)) ? (LK_W'(1) << o) : '0;
    endfunction

    logic [OI_W-1:0] w_ci;
    logic [LK_W-1:0] w_hd;
    logic [LK_W-1:0] w_half;
    logic [XW-1:0]   w_bsum;
    logic [OW-1:0]   w_cm1;
    logic [XW-1:0]   w_add;
    logic [CW-1:0]   w_sub;
    logic [LK_W-1:0] w_mb;
    assign w_ci   = OI_W'(r_cur);
    assign w_hd   = r_head[w_ci];
    assign w_cm1  = r_cur - OW'(1);
    assign w_half = pow2(w_cm1);
    assign w_bsum = XW'(r_f) + XW'(w_half);
    assign w_add  = XW'(r_free) + XW'(pow2(r_orig));
    assign w_sub  = CW'(pow2(r_req));
    assign w_mb   = r_f ^ pow2(r_cur);

    // memory address and write data for the current step
    always_comb begin
        w_we_f = 1'b0; w_we_o = 1'b0; w_we_n = 1'b0; w_we_p = 1'b0;
        w_a_f = FA_W'(r_f); w_a_o = FA_W'(r_f);
        w_a_n = FA_W'(r_f); w_a_p = FA_W'(r_f);
        w_d_f = F_BUD; w_d_o = r_cur; w_d_n = NIL; w_d_p = NIL;
        w_ra = FA_W'(r_f);
        unique case (r_state)
            S_CLEAR: begin
                w_we_f = 1'b1; w_we_o = 1'b1; w_we_n = 1'b1; w_we_p = 1'b1;
                w_a_f = FA_W'(r_clr); w_a_o = FA_W'(r_clr);
                w_a_n = FA_W'(r_clr); w_a_p = FA_W'(r_clr);
                w_d_f = F_RES; w_d_o = '0;
            end
            S_UL_RD: w_ra = FA_W'(r_b);
            // links of the block being unlinked are on the read port here
            S_UL_P: begin
                w_ra = FA_W'(r_b);
                if (is_link(r_rd_prev)) begin
                    w_we_n = 1'b1; w_a_n = FA_W'(r_rd_prev); w_d_n = lk(r_rd_next);
                end
            end
            S_UL_N: begin
                w_ra = FA_W'(r_b);
                if (is_link(r_n)) begin
                    w_we_p = 1'b1; w_a_p = FA_W'(r_n); w_d_p = lk(r_p);
                end
            end
            S_UL_DONE: begin
                w_we_n = 1'b1; w_we_p = 1'b1;
                w_a_n = FA_W'(r_b); w_a_p = FA_W'(r_b);
                if (!r_ul_alloc) begin
                    w_we_f = 1'b1; w_we_o = 1'b1;
                    w_a_f = FA_W'(r_b); w_a_o = FA_W'(r_b);
                    w_d_f = r_rd_flags & ~F_BUD; w_d_o = '0;
                end
            end
            S_SP_STEP: if (w_bsum < XW'(MAX_FRAMES)) begin
                w_we_f = 1'b1; w_we_o = 1'b1; w_we_n = 1'b1; w_we_p = 1'b1;
                w_a_f = FA_W'(w_bsum); w_a_o = FA_W'(w_bsum);
                w_a_n = FA_W'(w_bsum); w_a_p = FA_W'(w_bsum);
                w_d_f = F_BUD; w_d_o = w_cm1; w_d_n = lk(r_head[OI_W'(w_cm1)]);
            end
            S_PU_PREV: if (is_link(r_n)) begin
                w_we_p = 1'b1; w_a_p = FA_W'(r_n); w_d_p = r_b;
            end
            S_A_FIN: begin
                w_we_f = 1'b1; w_we_o = 1'b1; w_d_f = r_uflags; w_d_o = r_req;
            end
            S_F_RD, S_F_CHK: begin
                if (r_state == S_F_RD && r_op == bpa_pkg::OP_ADD) begin
                    w_we_f = 1'b1; w_we_o = 1'b1; w_d_f = '0; w_d_o = '0;
                end
                if (r_state == S_F_CHK && (r_op == bpa_pkg::OP_ADD ||
                    (r_rd_flags & (F_RES | F_BUD)) == '0)) begin
                    w_we_f = 1'b1; w_d_f = F_BUD;
                end
            end
            S_M_RD: w_ra = FA_W'(w_mb);
            S_M_CHK: w_ra = FA_W'(r_b);
            S_F_FIN: begin
                w_we_f = 1'b1; w_we_o = 1'b1; w_we_n = 1'b1; w_we_p = 1'b1;
                w_d_f = F_BUD; w_d_o = r_cur; w_d_n = lk(w_hd);
            end
            S_PU_SELF: if (is_link(r_n)) begin
                w_we_p = 1'b1; w_a_p = FA_W'(r_n); w_d_p = r_f;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_limit <= CW'(MAX_FRAMES);
            r_free  <= '0;
            o_done  <= 1'b0;
            for (int i = 0; i < int'(NUM_ORDERS); i++) r_head[i] <= NIL;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LK_W'(1);
                    if (r_clr == NIL - LK_W'(1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) begin
                    r_op     <= i_opcode;
                    r_req    <= i_order;
                    r_uflags <= i_page_flags_in;
                    r_f      <= LK_W'(i_frame);
                    r_cur    <= i_order;
                    o_frame_out <= '0;
                    if (i_opcode == bpa_pkg::OP_ALLOC) begin
                        if (i_order >= OW'(NUM_ORDERS)) begin
                            o_status <= bpa_pkg::ST_NO_MEM; r_state <= S_DONE;
                        end else r_state <= S_A_SCAN;
                    end else if (i_opcode == bpa_pkg::OP_UNDEF ||
                                 XW'(i_frame) >= XW'(MAX_FRAMES)) begin
                        o_status <= bpa_pkg::ST_BAD_ARG; r_state <= S_DONE;
                    end else r_state <= S_F_RD;
                end
                S_A_SCAN: begin
                    if (is_link(w_hd)) begin
                        r_f <= w_hd; r_b <= w_hd; r_ul_alloc <= 1'b1;
                        r_state <= S_UL_RD;
                    end else if (r_cur == OW'(NUM_ORDERS - 1)) begin
                        o_status <= bpa_pkg::ST_NO_MEM; r_state <= S_DONE;
                    end else r_cur <= r_cur + OW'(1);
                end
                S_UL_RD: r_state <= S_UL_P;
                S_UL_P: begin
                    r_p <= r_rd_prev; r_n <= r_rd_next;
                    if (!is_link(r_rd_prev) && r_head[w_ci] == r_b)
                        r_head[w_ci] <= lk(r_rd_next);
                    r_state <= S_UL_N;
                end
                S_UL_N: r_state <= S_UL_DONE;
                S_UL_DONE: begin
                    if (r_ul_alloc) r_state <= S_SP_HEAD;
                    else begin
                        r_f <= r_f & ~pow2(r_cur);
                        r_cur <= r_cur + OW'(1);
                        r_state <= S_M_RD;
                    end
                end
                // split: one upper half per visit
                S_SP_HEAD: r_state <= (r_cur > r_req) ? S_SP_STEP : S_A_FIN;
                S_SP_STEP: begin
                    r_cur <= w_cm1;
                    if (w_bsum < XW'(MAX_FRAMES)) begin
                        r_b <= LK_W'(w_bsum);
                        r_n <= r_head[OI_W'(w_cm1)];
                        r_head[OI_W'(w_cm1)] <= LK_W'(w_bsum);
                        r_state <= S_PU_PREV;
                    end else r_state <= S_SP_HEAD;
                end
                S_PU_PREV: r_state <= S_SP_HEAD;
                S_A_FIN: begin
                    r_free <= (r_free >= w_sub) ? r_free - w_sub : '0;
                    o_frame_out <= bpa_pkg::FRAME_W'(r_f);
                    o_status <= bpa_pkg::ST_OK;
                    r_state <= S_DONE;
                end
                S_F_RD: r_state <= S_F_CHK;
                S_F_CHK: begin
                    if (r_op != bpa_pkg::OP_ADD &&
                        (r_rd_flags & (F_RES | F_BUD)) != '0) begin
                        o_status <= bpa_pkg::ST_BAD_ST; r_state <= S_DONE;
                    end else begin
                        r_cur  <= (r_op == bpa_pkg::OP_ADD) ? '0 :
                                  (r_rd_order >= OW'(NUM_ORDERS)) ?
                                  OW'(NUM_ORDERS - 1) : r_rd_order;
                        r_orig <= (r_op == bpa_pkg::OP_ADD) ? '0 :
                                  (r_rd_order >= OW'(NUM_ORDERS)) ?
                                  OW'(NUM_ORDERS - 1) : r_rd_order;
                        r_state <= S_M_RD;
                    end
                end
                S_M_RD: begin
                    if (r_cur >= OW'(NUM_ORDERS - 1) || XW'(w_mb) >= XW'(r_limit) ||
                        w_mb >= NIL) r_state <= S_F_FIN;
                    else begin
                        r_b <= w_mb; r_state <= S_M_CHK;
                    end
                end
                S_M_CHK: begin
                    if ((r_rd_flags & F_BUD) == '0 || r_rd_order != r_cur)
                        r_state <= S_F_FIN;
                    else begin
                        r_ul_alloc <= 1'b0; r_state <= S_UL_P;
                    end
                end
                S_M_CLR: r_state <= S_F_FIN;
                S_F_FIN: begin
                    r_n <= w_hd;
                    r_head[w_ci] <= r_f;
                    r_state <= S_PU_SELF;
                end
                S_PU_SELF: begin
                    r_free <= (w_add > XW'(FREE_MAX)) ? FREE_MAX : CW'(w_add);
                    o_status <= bpa_pkg::ST_OK;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_free_count = r_free;

    // result strobe comes only out of the done step
    a_done_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_DONE) else $error("stray done");
    // a failed item reports frame zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != bpa_pkg::ST_OK) |-> o_frame_out == '0)
        else $error("frame on failure");
    // free count moves only when a command completes
    a_free_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_free) || $past(r_state) != S_IDLE)
        else $error("free count drift");

endmodule
`default_nettype wire

// ----- tb/buddy_page_allocator_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// buddy_page_allocator_tb
// Self-checking bench for the buddy page allocator: a behavioral model of
// the frame records and free lists predicts status, frame and free count
// for every command; a scoreboard compares each o_done result in order.
// ---------------------------------------------------------------------------
module buddy_page_allocator_tb;

    localparam int unsigned NIL      = bpa_pkg::MAX_FRAMES;
    localparam int unsigned CNT_MAX  = 8191;
    localparam logic [15:0] F_RES    = 16'(1 << bpa_pkg::RESERVED_BIT);
    localparam logic [15:0] F_BUD    = 16'(1 << bpa_pkg::BUDDY_BIT);
    localparam int unsigned CYC_LIMIT = 2000000;

    typedef struct packed {
        bpa_pkg::t_status st;
        logic [11:0]      frm;
        logic [12:0]      cnt;
    } t_alloc_res;

    class alloc_scoreboard;
        t_alloc_res pending[$];
        int errors;
        function void note(t_alloc_res r);
            pending.push_back(r);
        endfunction
        function void check(t_alloc_res got);
            t_alloc_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %0d frame %0d count %0d",
                         $time, got.st, got.frm, got.cnt);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.st != want.st) begin
                $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                errors++;
            end
            if (got.frm != want.frm) begin
                $display("%0t: frame expected %0d actual %0d", $time, want.frm, got.frm);
                errors++;
            end
            if (got.cnt != want.cnt) begin
                $display("%0t: free count expected %0d actual %0d",
                         $time, want.cnt, got.cnt);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [12:0] i_cfg_wdata = 0;
    logic        i_start = 0;
    logic [1:0]  i_opcode = 0;
    logic [3:0]  i_order = 0;
    logic [15:0] i_page_flags_in = 0;
    logic [11:0] i_frame = 0;
    logic        o_busy, o_done;
    logic [1:0]  o_status;
    logic [11:0] o_frame_out;
    logic [12:0] o_free_count;

    buddy_page_allocator i_dut (.*);

    always #10 i_clk = ~i_clk;

    // model of the allocator state
    int unsigned lim;
    logic [15:0] m_flags [bpa_pkg::MAX_FRAMES];
    int unsigned m_ord   [bpa_pkg::MAX_FRAMES];
    int unsigned m_next  [bpa_pkg::MAX_FRAMES];
    int unsigned m_prev  [bpa_pkg::MAX_FRAMES];
    int unsigned m_head  [bpa_pkg::NUM_ORDERS];
    int unsigned m_free;

    alloc_scoreboard sb;
    int unsigned cycles, n_alloc_ok, n_free_ok, n_fail;

    function automatic bit lnk(int unsigned v);
        return v < bpa_pkg::MAX_FRAMES;
    endfunction

    function automatic void push_blk(int unsigned f, int unsigned o);
        int unsigned h;
        h = m_head[o];
        m_next[f] = lnk(h) ? h : NIL;
        m_prev[f] = NIL;
        if (lnk(h)) m_prev[h] = f;
        m_head[o] = f;
    endfunction

    function automatic void unlink_blk(int unsigned f, int unsigned o);
        int unsigned p, n;
        p = m_prev[f];
        n = m_next[f];
        if (lnk(p)) m_next[p] = lnk(n) ? n : NIL;
        else if (m_head[o] == f) m_head[o] = lnk(n) ? n : NIL;
        if (lnk(n)) m_prev[n] = lnk(p) ? p : NIL;
        m_next[f] = NIL;
        m_prev[f] = NIL;
    endfunction

    function automatic bpa_pkg::t_status free_frame(int unsigned f);
        int unsigned o, o0, b;
        if (f >= bpa_pkg::MAX_FRAMES) return bpa_pkg::ST_BAD_ARG;
        if ((m_flags[f] & (F_RES | F_BUD)) != 0) return bpa_pkg::ST_BAD_ST;
        o = m_ord[f];
        if (o >= bpa_pkg::NUM_ORDERS) o = bpa_pkg::NUM_ORDERS - 1;
        o0 = o;
        m_flags[f] = F_BUD;
        while (o < bpa_pkg::NUM_ORDERS - 1) begin
            b = f ^ (1 << o);
            if (b >= lim || b >= bpa_pkg::MAX_FRAMES) break;
            if ((m_flags[b] & F_BUD) == 0 || m_ord[b] != o) break;
            unlink_blk(b, o);
            m_flags[b] = m_flags[b] & ~F_BUD;
            m_ord[b] = 0;
            f = f & ~(1 << o);
            o++;
        end
        m_flags[f] = F_BUD;
        m_ord[f] = o;
        m_next[f] = NIL;
        m_prev[f] = NIL;
        push_blk(f, o);
        m_free = (m_free + (1 << o0) > CNT_MAX) ? CNT_MAX : m_free + (1 << o0);
        return bpa_pkg::ST_OK;
    endfunction

    function automatic t_alloc_res predict_alloc(bpa_pkg::t_opcode op, int unsigned o,
                                                 logic [15:0] fl, int unsigned f);
        t_alloc_res r;
        int unsigned c, h, b;
        r.frm = 0;
        r.st = bpa_pkg::ST_NO_MEM;
        case (op)
            bpa_pkg::OP_ALLOC: begin
                if (o < bpa_pkg::NUM_ORDERS) begin
                    for (c = o; c < bpa_pkg::NUM_ORDERS; c++) begin
                        h = m_head[c];
                        if (!lnk(h)) continue;
                        unlink_blk(h, c);
                        while (c > o) begin
                            c--;
                            b = h + (1 << c);
                            if (b < bpa_pkg::MAX_FRAMES) begin
                                m_flags[b] = F_BUD;
                                m_ord[b] = c;
                                push_blk(b, c);
                            end
                        end
                        m_flags[h] = fl;
                        m_ord[h] = o;
                        m_free = (m_free >= (1 << o)) ? m_free - (1 << o) : 0;
                        r.st = bpa_pkg::ST_OK;
                        r.frm = h[11:0];
                        break;
                    end
                end
            end
            bpa_pkg::OP_FREE: r.st = free_frame(f);
            bpa_pkg::OP_ADD: begin
                m_flags[f] = 0;
                m_ord[f] = 0;
                r.st = free_frame(f);
            end
            default: r.st = bpa_pkg::ST_BAD_ARG;
        endcase
        if (r.st != bpa_pkg::ST_OK) r.frm = 0;
        if (r.st == bpa_pkg::ST_OK) begin
            if (op == bpa_pkg::OP_ALLOC) n_alloc_ok++; else n_free_ok++;
        end else n_fail++;
        r.cnt = m_free[12:0];
        return r;
    endfunction

    task automatic issue(bpa_pkg::t_opcode op, int unsigned o, logic [15:0] fl,
                         int unsigned f);
        i_start <= 1;
        i_opcode <= op;
        i_order <= o[3:0];
        i_page_flags_in <= fl;
        i_frame <= f[11:0];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note(predict_alloc(op, o, fl, f));
        // gap between bursts
        if ($urandom_range(0, 5) == 0) begin
            i_start <= 0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(int unsigned v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v[12:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        lim = v;
        @(posedge i_clk);
    endtask

    task automatic rand_item(int unsigned region);
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 45)
            issue(bpa_pkg::OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                  : $urandom_range(0, 4), 16'($urandom), 0);
        else if (k < 75)
            issue(bpa_pkg::OP_FREE, 0, 16'($urandom), $urandom_range(0, region));
        else if (k < 97)
            issue(bpa_pkg::OP_ADD, 0, 16'($urandom), $urandom_range(0, region));
        else
            issue(bpa_pkg::OP_UNDEF, $urandom_range(0, 15), 16'($urandom),
                  $urandom_range(0, 4095));
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_done)
            sb.check(t_alloc_res'{bpa_pkg::t_status'(o_status), o_frame_out,
                                  o_free_count});
        if (cycles > CYC_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned i;
        sb = new();
        lim = 4096;
        for (i = 0; i < bpa_pkg::MAX_FRAMES; i++) begin
            m_flags[i] = F_RES;
            m_ord[i] = 0;
            m_next[i] = NIL;
            m_prev[i] = NIL;
        end
        for (i = 0; i < bpa_pkg::NUM_ORDERS; i++) m_head[i] = NIL;
        m_free = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty lists, bad args, reserved frames, extremes
        issue(bpa_pkg::OP_ALLOC, 0, 16'hffff, 0);
        issue(bpa_pkg::OP_ALLOC, 15, 16'h0000, 4095);
        issue(bpa_pkg::OP_ALLOC, 11, 16'h1234, 0);
        issue(bpa_pkg::OP_FREE, 0, 0, 5);
        issue(bpa_pkg::OP_UNDEF, 15, 16'hffff, 4095);
        issue(bpa_pkg::OP_ADD, 0, 0, 4095);
        issue(bpa_pkg::OP_ADD, 0, 0, 4094);
        issue(bpa_pkg::OP_ADD, 0, 0, 0);
        issue(bpa_pkg::OP_ADD, 0, 0, 1);
        issue(bpa_pkg::OP_FREE, 0, 0, 1);
        issue(bpa_pkg::OP_ALLOC, 0, 16'haaaa, 0);
        issue(bpa_pkg::OP_FREE, 0, 0, 0);
        issue(bpa_pkg::OP_ALLOC, 10, 16'h5555, 0);
        issue(bpa_pkg::OP_ALLOC, 1, 16'h0000, 0);
        issue(bpa_pkg::OP_FREE, 0, 0, 0);
        // add page of a frame already on a list
        issue(bpa_pkg::OP_ADD, 0, 0, 0);
        for (i = 0; i < 8; i++) issue(bpa_pkg::OP_ADD, 0, 0, 2048 + i);
        issue(bpa_pkg::OP_ALLOC, 2, 16'hfffc, 0);

        set_limit(0);
        for (i = 0; i < 150; i++) rand_item(63);
        set_limit(8191);
        for (i = 0; i < 200; i++) rand_item(255);
        set_limit(4096);
        for (i = 0; i < 300; i++) rand_item(($urandom_range(0, 9) == 0) ? 4095 : 511);
        set_limit($urandom_range(1, 4095));
        for (i = 0; i < 300; i++) rand_item(1023);
        drain();

        $display("ran %0d successful allocs, %0d successful frees or adds, %0d rejected",
                 n_alloc_ok, n_free_ok, n_fail);
        $display("page limits 0, 8191, 4096 and %0d exercised", lim);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- buddy_page_allocator.f -----
hdl/bpa_pkg.sv
hdl/buddy_page_allocator.sv
tb/buddy_page_allocator_tb.sv
